[src/sfcc_pkg.sv]
// ----------------------------------------------------------------------------
// sfcc_pkg: shared definitions for the share frame CRC checker
// Types, codes, constants and the byte-wise CRC-32 step used by the checker.
// ----------------------------------------------------------------------------
package sfcc_pkg;

  // Stored header length default and the smallest legal share length.
  localparam int HDR_BYTES_DEF = 8;
  localparam logic [5:0] MIN_SHARE_BYTES = 6'd12;
  localparam logic [5:0] CRC_BYTES = 6'd4;
  localparam logic [5:0] TAG_BYTES = 6'd3;

  // Tag that opens every share.
  localparam logic [7:0] TAG_BYTE0 = 8'hD9;
  localparam logic [7:0] TAG_BYTE1 = 8'h01;
  localparam logic [7:0] TAG_BYTE2 = 8'h35;

  // Reflected CRC-32 polynomial, start value all ones.
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_SHARE_BYTES = 1'b0,
    CFG_SHARE_TOTAL = 1'b1
  } cfg_idx_t;

  // Failure reason codes, lowest code wins within one share.
  typedef enum logic [1:0] {
    REASON_NONE   = 2'd0,
    REASON_TAG    = 2'd1,
    REASON_HEADER = 2'd2,
    REASON_CRC    = 2'd3
  } reason_t;

  // Verdict handed from the check core to the output register.
  typedef struct packed {
    logic       done;
    logic       check_ok;
    logic [7:0] failing_share;
    reason_t    fail_reason;
  } verdict_t;

  // Expected tag byte for positions zero to two.
  function automatic logic [7:0] tag_byte(input logic [1:0] idx);
    logic [7:0] t;
    unique case (idx)
      2'd0:    t = TAG_BYTE0;
      2'd1:    t = TAG_BYTE1;
      default: t = TAG_BYTE2;
    endcase
    return t;
  endfunction

  // One byte of the reflected CRC-32, eight shift steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[src/sfcc_in_reg.sv]
// ----------------------------------------------------------------------------
// sfcc_in_reg: input register of the share frame CRC checker
// Holds one accepted word until the check core consumes it.
// ----------------------------------------------------------------------------
module sfcc_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       advance,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  // A new word enters when the register is empty or is drained this cycle.
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_valid ? 1'b1 : (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

endmodule

[src/sfcc_check_core.sv]
// ----------------------------------------------------------------------------
// sfcc_check_core: per-byte share checks and stream state
// Tracks position and share, runs the CRC, compares tag and header bytes and
// keeps the first failure until the verdict at the end of the stream.
// ----------------------------------------------------------------------------
module sfcc_check_core #(
  parameter int HEADER_COMPARE_BYTES = sfcc_pkg::HDR_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic [5:0]         share_bytes,
  input  logic [7:0]         share_total,
  output sfcc_pkg::verdict_t verdict
);

  localparam int HIDX_W = (HEADER_COMPARE_BYTES > 1) ? $clog2(HEADER_COMPARE_BYTES) : 1;
  localparam logic [5:0] HDR_LEN = 6'(HEADER_COMPARE_BYTES);

  logic [5:0]        pos_r, pos_nxt;
  logic [7:0]        share_r, share_nxt;
  logic [31:0]       crc_r, crc_nxt;
  logic              failed_r, failed_nxt;
  logic [7:0]        fshare_r, fshare_nxt;
  sfcc_pkg::reason_t freason_r, freason_nxt;
  logic [7:0]        hdr_r [HEADER_COMPARE_BYTES];

  logic [5:0]        len;
  logic [5:0]        body;
  logic [7:0]        count;
  logic              last_byte;
  logic              hdr_hit;
  logic [HIDX_W-1:0] hidx;
  logic              tag_bad;
  logic              hdr_bad;
  logic              crc_bad;
  logic [5:0]        k_full;
  logic [1:0]        k;
  logic [31:0]       crc_fin;
  logic [7:0]        expect_byte;
  sfcc_pkg::reason_t code;
  logic              fault;
  logic              flag_upd;
  logic [7:0]        share_upd;
  sfcc_pkg::reason_t reason_upd;

  // Clamp the configuration to its legal range.
  assign len       = (share_bytes < sfcc_pkg::MIN_SHARE_BYTES) ?
                     sfcc_pkg::MIN_SHARE_BYTES : share_bytes;
  assign body      = len - sfcc_pkg::CRC_BYTES;
  assign count     = (share_total == 8'd0) ? 8'd1 : share_total;
  assign last_byte = pos_r >= (len - 6'd1);

  // Tag and header comparisons.
  assign hdr_hit = pos_r < HDR_LEN;
  assign hidx    = pos_r[HIDX_W-1:0];
  assign tag_bad = (pos_r < sfcc_pkg::TAG_BYTES) &&
                   (data_byte != sfcc_pkg::tag_byte(pos_r[1:0]));
  assign hdr_bad = hdr_hit && (share_r != 8'd0) && (hdr_r[hidx] != data_byte);

  // Checksum bytes compare against the finished CRC, most significant first.
  assign k_full  = pos_r - body;
  assign k       = (k_full > 6'd3) ? 2'd3 : k_full[1:0];
  assign crc_fin = ~crc_r;

  always_comb begin
    unique case (k)
      2'd0:    expect_byte = crc_fin[31:24];
      2'd1:    expect_byte = crc_fin[23:16];
      2'd2:    expect_byte = crc_fin[15:8];
      default: expect_byte = crc_fin[7:0];
    endcase
  end

  assign crc_bad = (pos_r >= body) && (expect_byte != data_byte);

  // Lowest fault code of this byte.
  always_comb begin
    priority if (tag_bad) begin
      code = sfcc_pkg::REASON_TAG;
    end else if (hdr_bad) begin
      code = sfcc_pkg::REASON_HEADER;
    end else if (crc_bad) begin
      code = sfcc_pkg::REASON_CRC;
    end else begin
      code = sfcc_pkg::REASON_NONE;
    end
  end

  assign fault = tag_bad || hdr_bad || crc_bad;

  // Record the first failing share; a lower code in that share replaces it.
  always_comb begin
    flag_upd   = failed_r;
    share_upd  = fshare_r;
    reason_upd = freason_r;
    if (fault) begin
      if (!failed_r) begin
        flag_upd   = 1'b1;
        share_upd  = share_r;
        reason_upd = code;
      end else if ((fshare_r == share_r) && (code < freason_r)) begin
        reason_upd = code;
      end
    end
  end

  // Next state of position, share, CRC and failure record.
  always_comb begin
    pos_nxt         = pos_r + 6'd1;
    share_nxt       = share_r;
    crc_nxt         = (pos_r < body) ? sfcc_pkg::crc_byte(crc_r, data_byte) : crc_r;
    failed_nxt      = flag_upd;
    fshare_nxt      = share_upd;
    freason_nxt     = reason_upd;
    verdict.done          = 1'b0;
    verdict.check_ok      = !flag_upd;
    verdict.failing_share = flag_upd ? share_upd : 8'd0;
    verdict.fail_reason   = flag_upd ? reason_upd : sfcc_pkg::REASON_NONE;
    if (last_byte) begin
      pos_nxt = 6'd0;
      crc_nxt = sfcc_pkg::CRC_INIT;
      if (share_r < (count - 8'd1)) begin
        share_nxt = share_r + 8'd1;
      end else begin
        verdict.done = 1'b1;
        share_nxt    = 8'd0;
        failed_nxt   = 1'b0;
        fshare_nxt   = 8'd0;
        freason_nxt  = sfcc_pkg::REASON_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 6'd0;
      share_r   <= 8'd0;
      crc_r     <= sfcc_pkg::CRC_INIT;
      failed_r  <= 1'b0;
      fshare_r  <= 8'd0;
      freason_r <= sfcc_pkg::REASON_NONE;
    end else if (step) begin
      pos_r     <= pos_nxt;
      share_r   <= share_nxt;
      crc_r     <= crc_nxt;
      failed_r  <= failed_nxt;
      fshare_r  <= fshare_nxt;
      freason_r <= freason_nxt;
    end
  end

  // Share 0 stores its header bytes for the later shares.
  always_ff @(posedge clk) begin
    if (step && hdr_hit && (share_r == 8'd0)) begin
      hdr_r[hidx] <= data_byte;
    end
  end

endmodule

[src/share_frame_crc_checker.sv]
// ----------------------------------------------------------------------------
// share_frame_crc_checker: top level of the share frame CRC checker
// Checks tag, header and CRC-32 of each share in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one stream byte per word. Each share is
//   share_bytes long; share_total shares make one stream. The out_ channel
//   carries one word per stream, after its final byte: check_ok, the first
//   failing share and the reason (tag, header, checksum).
//   The cfg_ channel writes share_bytes (index 0) and share_total (index 1); it is
//   always ready, to be written only while the checker is idle (not enforced).
// Timing:
//   One byte per cycle sustained while no verdict waits on a full output register.
//   A byte is held in the input register, is checked by the combinational core
//   (byte-wise CRC step and compares), and at the end of a stream the verdict is
//   registered in the output register, which offers it on the out_ channel.
// Reset:
//   Synchronous, active low. Position, share counter, CRC and the failure
//   record clear; share_bytes returns to 12 and share_total to 1.
// Stall:
//   While a verdict waits on out_ready, bytes that give no verdict keep
//   flowing; a byte that finishes the next stream waits in the input register.
// ----------------------------------------------------------------------------
module share_frame_crc_checker #(
  parameter int HEADER_COMPARE_BYTES = sfcc_pkg::HDR_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_check_ok,
  output logic [7:0] out_failing_share,
  output logic [1:0] out_fail_reason,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic               hold_valid;
  logic [7:0]         hold_byte;
  logic               advance;
  logic               out_free;
  sfcc_pkg::verdict_t verdict;

  logic [5:0]         share_bytes_r;
  logic [7:0]         share_total_r;
  logic               out_valid_r, out_valid_nxt;
  logic               check_ok_r;
  logic [7:0]         failing_share_r;
  logic [1:0]         fail_reason_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      share_bytes_r <= sfcc_pkg::MIN_SHARE_BYTES;
      share_total_r <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sfcc_pkg::cfg_idx_t'(cfg_index))
        sfcc_pkg::CFG_SHARE_BYTES: share_bytes_r <= cfg_data[5:0];
        sfcc_pkg::CFG_SHARE_TOTAL: share_total_r <= cfg_data;
        default:                   share_total_r <= share_total_r;
      endcase
    end
  end

  // Input register.
  sfcc_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .advance      (advance),
    .hold_valid   (hold_valid),
    .hold_byte    (hold_byte)
  );

  // Check core.
  sfcc_check_core #(
    .HEADER_COMPARE_BYTES (HEADER_COMPARE_BYTES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .data_byte   (hold_byte),
    .share_bytes (share_bytes_r),
    .share_total (share_total_r),
    .verdict     (verdict)
  );

  // The held byte advances unless its verdict finds the output register full.
  assign out_free = !out_valid_r || out_ready;
  assign advance  = hold_valid && (!verdict.done || out_free);

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (advance && verdict.done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && verdict.done) begin
      check_ok_r      <= verdict.check_ok;
      failing_share_r <= verdict.failing_share;
      fail_reason_r   <= verdict.fail_reason;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_check_ok      = check_ok_r;
  assign out_failing_share = failing_share_r;
  assign out_fail_reason   = fail_reason_r;

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: regression bench for the share frame CRC checker
// Streams tag-led shares with a trailing CRC-32 through the checker, with clean
// and corrupted shares, clamped and extreme frame settings, and settings
// changed part way through a stream. A local model of the checker predicts
// each verdict, and a monitor compares every verdict field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int CLK_PERIOD = 12;
  localparam int HDR_CMP = sfcc_pkg::HDR_BYTES_DEF;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [23:0] TAG_WORD = {sfcc_pkg::TAG_BYTE2, sfcc_pkg::TAG_BYTE1,
                                      sfcc_pkg::TAG_BYTE0};

  // Verdict that the checker should report for one stream.
  typedef struct {
    logic               ok;
    logic [7:0]         share;
    sfcc_pkg::reason_t  reason;
  } exp_verdict_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_data_byte;
  logic               out_valid;
  logic               out_ready;
  logic               out_check_ok;
  logic [7:0]         out_failing_share;
  logic [1:0]         out_fail_reason;
  logic               cfg_valid;
  logic               cfg_ready;
  sfcc_pkg::cfg_idx_t cfg_index;
  logic [7:0]         cfg_data;

  // Frame settings as last written.
  logic [5:0] cfg_share_bytes = sfcc_pkg::MIN_SHARE_BYTES;
  logic [7:0] cfg_share_total = 8'd1;

  // Checker state as the model sees it.
  logic [5:0]        byte_pos = '0;
  logic [7:0]        share_idx = '0;
  logic [31:0]       crc_reg = sfcc_pkg::CRC_INIT;
  logic [7:0]        first_hdr [8];
  logic              pend_failed = 1'b0;
  logic [7:0]        pend_share = '0;
  sfcc_pkg::reason_t pend_reason = sfcc_pkg::REASON_NONE;

  exp_verdict_t expected_verdicts[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_cycles = 0;
  int bytes_sent = 0;
  int verdicts_predicted = 0;
  int verdicts_seen = 0;
  int failed_verdicts = 0;
  int verdict_errors = 0;

  share_frame_crc_checker u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_check_ok      (out_check_ok),
    .out_failing_share (out_failing_share),
    .out_fail_reason   (out_fail_reason),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Bit-serial CRC-32 update, least significant data bit first.
  function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ (sfcc_pkg::CRC_POLY & {32{r[0] ^ d[i]}});
    end
    return r;
  endfunction

  // Share length and count after clamping of out-of-range settings.
  function automatic int frame_len();
    return (cfg_share_bytes < sfcc_pkg::MIN_SHARE_BYTES) ?
           int'(sfcc_pkg::MIN_SHARE_BYTES) : int'(cfg_share_bytes);
  endfunction

  function automatic int frame_count();
    return (cfg_share_total == 8'd0) ? 1 : int'(cfg_share_total);
  endfunction

  // Record a fault; the first failing share wins, and within it the lowest code.
  task automatic flag_fault(input sfcc_pkg::reason_t code);
    if (!pend_failed) begin
      pend_failed = 1'b1;
      pend_share = share_idx;
      pend_reason = code;
    end else if (pend_share == share_idx && code < pend_reason) begin
      pend_reason = code;
    end
  endtask

  // Advance the model by one accepted byte and queue a verdict at stream end.
  task automatic absorb_byte(input logic [7:0] b);
    int unsigned len, cnt, p, body, k;
    logic [31:0] fin;
    exp_verdict_t v;
    len = frame_len();
    cnt = frame_count();
    p = byte_pos;
    body = len - 4;
    if (p < 3 && b != TAG_WORD[8*p +: 8]) flag_fault(sfcc_pkg::REASON_TAG);
    if (p < HDR_CMP) begin
      if (share_idx == 8'd0) first_hdr[p] = b;
      else if (first_hdr[p] != b) flag_fault(sfcc_pkg::REASON_HEADER);
    end
    if (p < body) begin
      crc_reg = crc32_update(crc_reg, b);
    end else begin
      // Positions past the last checksum byte compare with the lowest CRC byte.
      k = (p - body > 3) ? 3 : p - body;
      fin = ~crc_reg;
      if (fin[8*(3-k) +: 8] != b) flag_fault(sfcc_pkg::REASON_CRC);
    end
    if (p < len - 1) begin
      byte_pos = 6'(p + 1);
      return;
    end
    byte_pos = '0;
    crc_reg = sfcc_pkg::CRC_INIT;
    if (share_idx < cnt - 1) begin
      share_idx = share_idx + 8'd1;
      return;
    end
    v.ok = !pend_failed;
    v.share = pend_failed ? pend_share : 8'd0;
    v.reason = pend_failed ? pend_reason : sfcc_pkg::REASON_NONE;
    expected_verdicts.push_back(v);
    verdicts_predicted++;
    share_idx = '0;
    pend_failed = 1'b0;
    pend_share = '0;
    pend_reason = sfcc_pkg::REASON_NONE;
  endtask

  // Offer one byte, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_byte(b);
    bytes_sent++;
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_byte(8'($urandom));
  endtask

  // Send one stream of well-formed shares; bad_share gets bad_pos corrupted,
  // and each share is damaged in one or two places with chance fault_pct.
  task automatic send_stream(input int len, input int shares, input int fault_pct,
                             input int bad_share, input int bad_pos);
    logic [7:0] hdr [8];
    logic [7:0] frame [64];
    logic [31:0] c;
    int s, j, at;
    hdr[0] = sfcc_pkg::TAG_BYTE0;
    hdr[1] = sfcc_pkg::TAG_BYTE1;
    hdr[2] = sfcc_pkg::TAG_BYTE2;
    for (j = 3; j < 8; j++) hdr[j] = 8'($urandom);
    for (s = 0; s < shares; s++) begin
      c = sfcc_pkg::CRC_INIT;
      for (j = 0; j < len - 4; j++) begin
        frame[j] = (j < 8) ? hdr[j] : 8'($urandom);
        c = crc32_update(c, frame[j]);
      end
      for (j = 0; j < 4; j++) frame[len-4+j] = ~c[31-8*j -: 8];
      if (s == bad_share) frame[bad_pos] = frame[bad_pos] ^ 8'hA5;
      if ($urandom_range(99) < fault_pct) begin
        repeat ($urandom_range(2, 1)) begin
          case ($urandom_range(2))
            0: begin
              at = $urandom_range(2);
            end
            1: begin
              at = $urandom_range(7, 3);
            end
            default: begin
              at = $urandom_range(len - 1);
            end
          endcase
          frame[at] = frame[at] ^ 8'($urandom_range(255, 1));
        end
      end
      for (j = 0; j < len; j++) send_byte(frame[j]);
    end
  endtask

  // Stop offering bytes until every verdict is in and the pipeline has drained.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both frame settings while the checker is idle.
  task automatic program_frame(input logic [7:0] bytes_word, input logic [7:0] total);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= sfcc_pkg::CFG_SHARE_BYTES;
    cfg_data <= bytes_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_share_bytes = bytes_word[5:0];
    cfg_index <= sfcc_pkg::CFG_SHARE_TOTAL;
    cfg_data <= total;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_share_total = total;
    cfg_valid <= 1'b0;
  endtask

  // Reset settings: one clean share, then one with a bad checksum byte.
  task automatic test_reset_values();
    send_stream(12, 1, 0, -1, 0);
    send_stream(12, 1, 0, 0, 11);
  endtask

  // Each failure reason in the second share, and a tag fault in share zero.
  task automatic test_fault_reasons();
    program_frame(8'd12, 8'd2);
    send_stream(12, 2, 0, 1, 0);
    send_stream(12, 2, 0, 1, 5);
    send_stream(12, 2, 0, 1, 10);
    send_stream(12, 2, 0, 0, 2);
  endtask

  // Share length below the minimum and a zero share count are clamped.
  task automatic test_clamped_config();
    program_frame(8'hC5, 8'd0);
    send_stream(12, 1, 0, -1, 0);
    program_frame(8'h80, 8'd0);
    send_stream(12, 1, 0, -1, 0);
  endtask

  // Shrink the frame while a stream is under way.
  task automatic test_midstream_change();
    program_frame(8'd20, 8'd2);
    send_noise(38);
    program_frame(8'd12, 8'd2);
    send_noise(1);
    program_frame(8'd12, 8'd3);
    send_noise(24);
    program_frame(8'd12, 8'd1);
    send_noise(12);
  endtask

  // Longest shares, with a payload byte of the last share corrupted so its checksum fails.
  task automatic test_largest_frame();
    program_frame(8'd63, 8'd2);
    send_stream(63, 2, 0, 1, 40);
  endtask

  // Long receiver stalls while the sender keeps offering short streams.
  task automatic test_backpressure();
    program_frame(8'd12, 8'd1);
    hold_off_cycles = 80;
    repeat (3) send_stream(12, 1, 20, -1, 0);
    settle();
    hold_off_cycles = 120;
    repeat (4) send_stream(12, 1, 20, -1, 0);
  endtask

  // Random settings, mostly well-formed streams with some noise and misalignment.
  task automatic test_random_traffic(input int byte_budget);
    int first_byte, len, cnt;
    logic [7:0] sb_word, tot;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < byte_budget) begin
      case ($urandom_range(9))
        0: begin
          sb_word = 8'd12;
        end
        1: begin
          sb_word = 8'd63;
        end
        2: begin
          sb_word = 8'($urandom_range(11));
        end
        default: begin
          sb_word = 8'($urandom_range(20, 12));
        end
      endcase
      sb_word[7:6] = 2'($urandom);
      case ($urandom_range(9))
        0: begin
          tot = 8'd0;
        end
        1, 2, 3, 4: begin
          tot = 8'd1;
        end
        5, 6, 7: begin
          tot = 8'd2;
        end
        default: begin
          tot = 8'($urandom_range(5, 3));
        end
      endcase
      program_frame(sb_word, tot);
      len = frame_len();
      cnt = frame_count();
      repeat ($urandom_range(2, 1)) begin
        case ($urandom_range(9))
          0: begin
            send_noise(len * cnt);
          end
          1: begin
            send_noise($urandom_range(len - 1, 1));
            send_stream(len, cnt, 30, -1, 0);
          end
          default: begin
            send_stream(len, cnt, 30, -1, 0);
          end
        endcase
      end
    end
  endtask

  // Verdict monitor: compares each accepted word and drives out_ready.
  initial begin : verdict_monitor
    exp_verdict_t v;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        verdicts_seen++;
        if (!out_check_ok) failed_verdicts++;
        if (expected_verdicts.size() == 0) begin
          $error("verdict word arrived with none pending");
          verdict_errors++;
        end else begin
          v = expected_verdicts.pop_front();
          if (out_check_ok !== v.ok) begin
            $error("check_ok: expected %0d, got %0d", v.ok, out_check_ok);
            verdict_errors++;
          end
          if (out_failing_share !== v.share) begin
            $error("failing_share: expected %0d, got %0d", v.share, out_failing_share);
            verdict_errors++;
          end
          if (out_fail_reason !== v.reason) begin
            $error("fail_reason: expected %0d, got %0d", v.reason, out_fail_reason);
            verdict_errors++;
          end
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Test sequence.
  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data_byte <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= sfcc_pkg::CFG_SHARE_BYTES;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 28;
    recv_idle_pct = 50;
    test_reset_values();
    test_fault_reasons();
    test_clamped_config();
    test_midstream_change();
    test_largest_frame();
    test_random_traffic(70);

    send_idle_pct = 50;
    recv_idle_pct = 28;
    test_random_traffic(70);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_traffic(70);

    settle();
    repeat (8) @(posedge clk);
    if (expected_verdicts.size() != 0) verdict_errors++;
    $display("Streamed %0d bytes and checked %0d verdicts, %0d of them reporting a bad share.",
             bytes_sent, verdicts_seen, failed_verdicts);
    $display("Covered share lengths 12 to 63, clamped and mid-stream settings, long stalls.");
    if (verdict_errors == 0) begin
      $display("share_frame_crc_checker regression: pass");
    end else begin
      $display("share_frame_crc_checker regression: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #(CLK_PERIOD * 600000);
    $display("share_frame_crc_checker regression: fail");
    $finish;
  end

endmodule

[sim.f]
src/sfcc_pkg.sv
src/sfcc_in_reg.sv
src/sfcc_check_core.sv
src/share_frame_crc_checker.sv
dv/tb.sv
